// ===== hdl/sdspcf_pkg.sv =====
package sdspcf_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int MAX_RADIUS_DEF = 3;

   localparam int DIM_W      = 9;
   localparam int RAD_W      = 2;
   localparam int VIS_W      = 17;
   localparam int DEPTH_W    = 24;
   localparam int COORD_W    = 8;
   localparam int QPOS_W     = 12;
   localparam int QUOT_W     = 17;
   localparam int WORD_W     = DEPTH_W + 1;
   localparam int REQ_DATA_W = 112;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = RSP_DATA_W - VIS_W - 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [VIS_W-1:0] ONE_Q16 = VIS_W'(65536);

   typedef enum logic [REQ_USER_W-1:0] {
      OP_WRITE = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_WIDTH  = 2'd0,
      CSR_MAP_HEIGHT = 2'd1,
      CSR_PCF_RADIUS = 2'd2,
      CSR_MIN_VIS    = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic capture;
      logic clr_step;
      logic scan;
      logic wr_update;
      logic div_start;
      logic mul;
      logic fin;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic scan_last;
      logic div_done;
   } sts_type;

endpackage

// ===== hdl/sdspcf_div.sv =====
module sdspcf_div import sdspcf_pkg::*; #(
   parameter int TW = 13
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TW-1:0]     num,
   input  logic [TW-1:0]     den,
   output logic              done,
   output logic [QUOT_W-1:0] quot
);

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic [TW-1:0]     rem_ff;
   logic [QUOT_W-1:0] feed_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              done_ff;
   logic [TW:0]       trial;
   logic [TW:0]       diff;
   logic              ge;

   // restoring division of num * 2^16 by den, num <= den
   assign trial = {rem_ff, feed_ff[QUOT_W-1]};
   assign ge    = trial >= {1'b0, den};
   assign diff  = trial - {1'b0, den};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(QUOT_W);
         end else if (cnt_ff != '0) begin
            cnt_ff  <= cnt_ff - 1'b1;
            done_ff <= (cnt_ff == CNT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= {1'b0, num[TW-1:1]};
         feed_ff <= {num[0], {(QUOT_W-1){1'b0}}};
         quot_ff <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff  <= ge ? diff[TW-1:0] : trial[TW-1:0];
         feed_ff <= {feed_ff[QUOT_W-2:0], 1'b0};
         quot_ff <= {quot_ff[QUOT_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== hdl/sdspcf_dpath.sv =====
module sdspcf_dpath import sdspcf_pkg::*; #(
   parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT     = MAX_HEIGHT_DEF,
   parameter int MAX_PCF_RADIUS = MAX_RADIUS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_wr,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int SIZE = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW   = (SIZE > 1) ? $clog2(SIZE) : 1;
   localparam int RW   = (MAX_PCF_RADIUS > 0) ? $clog2(MAX_PCF_RADIUS + 1) : 1;
   localparam int OW   = RW + 1;
   localparam int FW   = RW + 1;
   localparam int PW   = 2 * FW;
   localparam int WW   = 2 * RW + 1;
   localparam int TW   = 4 * RW + 1;
   localparam int IW   = (AW > 2 * DIM_W + 1) ? AW : 2 * DIM_W + 1;
   localparam int SW   = DIM_W + 2;
   localparam int MW   = 2 * VIS_W;

   // configuration
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic [RAD_W-1:0] radius_ff;
   logic [VIS_W-1:0] minvis_ff;
   logic [DIM_W-1:0] w_eff;
   logic [DIM_W-1:0] h_eff;
   logic [RW-1:0]    r_eff;
   logic [VIS_W-1:0] m_eff;

   // captured item
   logic [COORD_W-1:0] wx_ff;
   logic [COORD_W-1:0] wy_ff;
   logic [DEPTH_W-1:0] wdepth_ff;
   logic [DIM_W-1:0]   cx_ff;
   logic [DIM_W-1:0]   cy_ff;
   logic [DEPTH_W-1:0] qdepth_ff;
   logic [DEPTH_W-1:0] bias_ff;
   logic [QPOS_W:0]    qx_sum;
   logic [QPOS_W:0]    qy_sum;

   // scan
   logic signed [OW-1:0] dx_ff;
   logic signed [OW-1:0] dy_ff;
   logic signed [OW-1:0] r_s;
   logic signed [OW-1:0] ax;
   logic signed [OW-1:0] ay;
   logic [FW-1:0]        fx;
   logic [FW-1:0]        fy;
   logic [PW-1:0]        wt_full;
   logic signed [SW-1:0] sx;
   logic signed [SW-1:0] sy;
   logic                 s_inmap;
   logic [DIM_W-1:0]     row;
   logic [DIM_W-1:0]     col;
   logic [IW-1:0]        idx_wide;
   logic [AW-1:0]        rd_addr;

   // store
   logic [WORD_W-1:0] mem [SIZE];
   logic [WORD_W-1:0] rd_word_ff;
   logic [AW-1:0]     addr_ff;
   logic [AW-1:0]     clr_cnt_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [WORD_W-1:0] mem_wdata;

   // filter pipeline
   logic                tap_valid_ff;
   logic                tap_inmap_ff;
   logic [WW-1:0]       tap_wt_ff;
   logic signed [DEPTH_W:0] limit;
   logic                lit;
   logic [TW-1:0]       lit_w_ff;
   logic [TW-1:0]       tot_w_ff;
   logic                w_inmap;
   logic                do_write;
   logic                div_done;
   logic [QUOT_W-1:0]   quot;
   logic [MW-1:0]       prod_ff;
   logic                res_written_ff;
   logic [VIS_W-1:0]    res_vis_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(256);
         height_ff <= DIM_W'(256);
         radius_ff <= RAD_W'(1);
         minvis_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MAP_WIDTH:  width_ff  <= csr_data[DIM_W-1:0];
            CSR_MAP_HEIGHT: height_ff <= csr_data[DIM_W-1:0];
            CSR_PCF_RADIUS: radius_ff <= csr_data[RAD_W-1:0];
            CSR_MIN_VIS:    minvis_ff <= csr_data[VIS_W-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0)                  w_eff = DIM_W'(1);
      else if (32'(width_ff) > MAX_WIDTH)  w_eff = DIM_W'(MAX_WIDTH);
      else                                 w_eff = width_ff;
      if (height_ff == '0)                 h_eff = DIM_W'(1);
      else if (32'(height_ff) > MAX_HEIGHT) h_eff = DIM_W'(MAX_HEIGHT);
      else                                 h_eff = height_ff;
      if (32'(radius_ff) > MAX_PCF_RADIUS) r_eff = RW'(MAX_PCF_RADIUS);
      else                                 r_eff = RW'(radius_ff);
      m_eff = (minvis_ff > ONE_Q16) ? ONE_Q16 : minvis_ff;
   end

   // texel centers: round Q8.4 half up (positions are never negative)
   assign qx_sum = {1'b0, req_tdata[51:40]} + (QPOS_W+1)'(8);
   assign qy_sum = {1'b0, req_tdata[63:52]} + (QPOS_W+1)'(8);
   assign r_s    = $signed({1'b0, r_eff});

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         wx_ff     <= req_tdata[7:0];
         wy_ff     <= req_tdata[15:8];
         wdepth_ff <= req_tdata[39:16];
         cx_ff     <= qx_sum[QPOS_W:4];
         cy_ff     <= qy_sum[QPOS_W:4];
         qdepth_ff <= req_tdata[87:64];
         bias_ff   <= req_tdata[111:88];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dx_ff <= -r_s;
         dy_ff <= -r_s;
      end else if (cmd.scan) begin
         if (dx_ff == r_s) begin
            dx_ff <= -r_s;
            dy_ff <= dy_ff + OW'(1);
         end else begin
            dx_ff <= dx_ff + OW'(1);
         end
      end
   end

   assign sts.scan_last = (dx_ff == r_s) && (dy_ff == r_s);

   always_comb begin
      ax      = dx_ff[OW-1] ? -dx_ff : dx_ff;
      ay      = dy_ff[OW-1] ? -dy_ff : dy_ff;
      fx      = {1'b0, r_eff} + FW'(1) - {1'b0, ax[RW-1:0]};
      fy      = {1'b0, r_eff} + FW'(1) - {1'b0, ay[RW-1:0]};
      wt_full = PW'(fx) * PW'(fy);
      sx      = $signed({2'b00, cx_ff}) + $signed({{(SW-OW){dx_ff[OW-1]}}, dx_ff});
      sy      = $signed({2'b00, cy_ff}) + $signed({{(SW-OW){dy_ff[OW-1]}}, dy_ff});
      s_inmap = !sx[SW-1] && !sy[SW-1]
                && (sx[SW-2:0] < {1'b0, w_eff}) && (sy[SW-2:0] < {1'b0, h_eff});
      if (cmd.scan) begin
         row = sy[DIM_W-1:0];
         col = sx[DIM_W-1:0];
      end else begin
         row = {1'b0, wy_ff};
         col = {1'b0, wx_ff};
      end
      idx_wide = IW'(row) * IW'(w_eff) + IW'(col);
      rd_addr  = idx_wide[AW-1:0];
   end

   // depth write: keep the nearer depth
   assign w_inmap  = ({1'b0, wx_ff} < w_eff) && ({1'b0, wy_ff} < h_eff);
   assign do_write = w_inmap && (!rd_word_ff[DEPTH_W]
                     || ($signed(wdepth_ff) < $signed(rd_word_ff[DEPTH_W-1:0])));

   assign mem_we    = cmd.clr_step || (cmd.wr_update && do_write);
   assign mem_waddr = cmd.clr_step ? clr_cnt_ff : addr_ff;
   assign mem_wdata = cmd.clr_step ? '0 : {1'b1, wdepth_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_word_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      addr_ff      <= rd_addr;
      tap_inmap_ff <= s_inmap;
      tap_wt_ff    <= wt_full[WW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         tap_valid_ff <= 1'b0;
      end else begin
         tap_valid_ff <= cmd.scan;
         if (cmd.clr_step) begin
            clr_cnt_ff <= sts.clr_last ? '0 : clr_cnt_ff + 1'b1;
         end
      end
   end

   assign sts.clr_last = (clr_cnt_ff == AW'(SIZE - 1));

   // empty entries and texels off the map are lit
   assign limit = $signed({bias_ff[DEPTH_W-1], bias_ff})
                + $signed({rd_word_ff[DEPTH_W-1], rd_word_ff[DEPTH_W-1:0]});
   assign lit   = !tap_inmap_ff || !rd_word_ff[DEPTH_W]
                  || ($signed({qdepth_ff[DEPTH_W-1], qdepth_ff}) <= limit);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lit_w_ff <= '0;
         tot_w_ff <= '0;
      end else if (tap_valid_ff) begin
         tot_w_ff <= tot_w_ff + TW'(tap_wt_ff);
         if (lit) begin
            lit_w_ff <= lit_w_ff + TW'(tap_wt_ff);
         end
      end
   end

   sdspcf_div #(
      .TW (TW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (lit_w_ff),
      .den   (tot_w_ff),
      .done  (div_done),
      .quot  (quot)
   );

   assign sts.div_done = div_done;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= MW'(ONE_Q16 - m_eff) * MW'(quot);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         res_written_ff <= 1'b0;
         res_vis_ff     <= '0;
      end else begin
         if (cmd.wr_update) begin
            res_written_ff <= do_write;
         end
         if (cmd.fin) begin
            res_vis_ff <= m_eff + prod_ff[32:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, res_vis_ff, res_written_ff};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== hdl/sdspcf_ctrl.sv =====
module sdspcf_ctrl import sdspcf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output cmd_type               cmd,
   input  sts_type               sts
);

   typedef enum logic [11:0] {
      S_INIT_CLR = 12'b0000_0000_0001,
      S_IDLE     = 12'b0000_0000_0010,
      S_CLR      = 12'b0000_0000_0100,
      S_WR_RD    = 12'b0000_0000_1000,
      S_WR_UPD   = 12'b0000_0001_0000,
      S_SCAN     = 12'b0000_0010_0000,
      S_DRAIN    = 12'b0000_0100_0000,
      S_DIV_GO   = 12'b0000_1000_0000,
      S_DIV_WAIT = 12'b0001_0000_0000,
      S_MUL      = 12'b0010_0000_0000,
      S_FIN      = 12'b0100_0000_0000,
      S_DONE     = 12'b1000_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_tready     = 1'b0;
      unique case (state_ff)
         S_INIT_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               unique case (op_type'(req_tuser))
                  OP_WRITE: state_in = S_WR_RD;
                  OP_QUERY: state_in = S_SCAN;
                  OP_CLEAR: state_in = S_CLR;
                  OP_NONE:  state_in = S_DONE;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_DONE;
         end
         S_WR_RD: state_in = S_WR_UPD;
         S_WR_UPD: begin
            cmd.wr_update = 1'b1;
            state_in      = S_DONE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_DIV_GO;
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (sts.div_done) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT_CLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== hdl/shadow_depth_store_pcf.sv =====
// Channel  Direction  Ports                              Content
// req      in         req_tvalid/tready/tdata/tuser      one operation
// rsp      out        rsp_tvalid/tready/tdata            one result per operation
// csr      in         csr_valid/ready/index/data         register write
//
// Write: a store read, then a conditional update, then the result. Query:
// (2r+1)^2 texel reads, one per store port cycle, then a 17-step bit-serial
// divide and a multiply. Clear: one store entry per cycle. After reset the
// same clearing pass runs and no item is taken until it ends. A new item is
// accepted while the previous result waits in the output register.
module shadow_depth_store_pcf import sdspcf_pkg::*; #(
   parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT     = MAX_HEIGHT_DEF,
   parameter int MAX_PCF_RADIUS = MAX_RADIUS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // write_x, write_y, write_depth, query_x, query_y, query_depth, bias
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // written, visibility, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;
   logic    csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   sdspcf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   sdspcf_dpath #(
      .MAX_WIDTH      (MAX_WIDTH),
      .MAX_HEIGHT     (MAX_HEIGHT),
      .MAX_PCF_RADIUS (MAX_PCF_RADIUS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .csr_wr    (csr_wr),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over a pending item");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.clr_step, cmd.scan, cmd.wr_update,
                cmd.div_start, cmd.mul, cmd.fin, cmd.out_load}))
      else $error("datapath commands overlap");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item taken while one is in flight");
`endif

endmodule

// ===== bench/tb_shadow_depth_store_pcf.sv =====
`timescale 1ns / 1ps

module tb_shadow_depth_store_pcf;
   import sdspcf_pkg::*;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int MAP_CELLS   = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
   localparam int Q1_22_ONE   = 4194304;
   localparam int PHASE_ITEMS = 195;

   typedef struct packed {
      op_type      op;
      logic [7:0]  wx;
      logic [7:0]  wy;
      logic [23:0] wd;
      logic [11:0] qx;
      logic [11:0] qy;
      logic [23:0] qd;
      logic [23:0] bias;
   } depth_req_type;

   typedef struct packed {
      logic             written;
      logic [VIS_W-1:0] visibility;
   } map_result_type;

   localparam int REQ_BITS = $bits(depth_req_type);

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // shadow copy of the depth map and registers
   logic [DEPTH_W-1:0] map_depth [MAP_CELLS];
   bit                 map_full  [MAP_CELLS];
   logic [DIM_W-1:0]   cfg_width;
   logic [DIM_W-1:0]   cfg_height;
   logic [RAD_W-1:0]   cfg_radius;
   logic [VIS_W-1:0]   cfg_min_vis;

   map_result_type predicted_results [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int cycles        = 0;
   int mismatches    = 0;
   int n_items       = 0;
   int n_results     = 0;
   int n_stored      = 0;
   int n_queries     = 0;
   int n_clears      = 0;
   int n_configs     = 0;

   shadow_depth_store_pcf dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                  predicted_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(string what, longint exp_v, longint got_v);
      mismatches++;
      if (mismatches <= 40)
         $display("MISMATCH result %0d %s: expected %0d got %0d", n_results, what, exp_v, got_v);
   endtask

   function automatic int eff_dim(logic [DIM_W-1:0] val, int max_v);
      if (val == 0) return 1;
      return (val > max_v) ? max_v : int'(val);
   endfunction

   function automatic void clear_map();
      for (int i = 0; i < MAP_CELLS; i++) begin
         map_full[i]  = 1'b0;
         map_depth[i] = '0;
      end
   endfunction

   // expected result of one item; updates the shadow map
   function automatic map_result_type apply_map_op(depth_req_type rq);
      map_result_type res;
      int     w, h, r, cx, cy, sx, sy, idx, lit_w, total_w, wt;
      longint frac, floor_v;
      bit     lit;
      res = '0;
      w = eff_dim(cfg_width, MAX_WIDTH_DEF);
      h = eff_dim(cfg_height, MAX_HEIGHT_DEF);
      case (rq.op)
         OP_WRITE: begin
            if (int'(rq.wx) < w && int'(rq.wy) < h) begin
               idx = int'(rq.wy) * w + int'(rq.wx);
               if (!map_full[idx] || $signed(rq.wd) < $signed(map_depth[idx])) begin
                  map_depth[idx] = rq.wd;
                  map_full[idx]  = 1'b1;
                  res.written    = 1'b1;
               end
            end
         end
         OP_QUERY: begin
            r = (int'(cfg_radius) > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(cfg_radius);
            cx = (int'(rq.qx) + 8) >> 4;
            cy = (int'(rq.qy) + 8) >> 4;
            floor_v = (cfg_min_vis > 65536) ? 65536 : longint'(cfg_min_vis);
            lit_w = 0;
            total_w = 0;
            for (int dy = -r; dy <= r; dy++) begin
               for (int dx = -r; dx <= r; dx++) begin
                  wt = (r + 1 - ((dx < 0) ? -dx : dx)) * (r + 1 - ((dy < 0) ? -dy : dy));
                  sx = cx + dx;
                  sy = cy + dy;
                  lit = 1'b1;
                  if (sx >= 0 && sy >= 0 && sx < w && sy < h) begin
                     idx = sy * w + sx;
                     if (map_full[idx])
                        lit = longint'($signed(rq.qd)) <=
                              longint'($signed(map_depth[idx])) + longint'($signed(rq.bias));
                  end
                  if (lit) lit_w += wt;
                  total_w += wt;
               end
            end
            frac = (longint'(lit_w) * 65536) / total_w;
            res.visibility = VIS_W'(floor_v + (((65536 - floor_v) * frac) >> 16));
         end
         OP_CLEAR: clear_map();
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      map_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_results.size() == 0) begin
            report_mismatch("unexpected result, tdata", 0, rsp_tdata);
         end else begin
            exp_r = predicted_results.pop_front();
            if (rsp_tdata[0] !== exp_r.written)
               report_mismatch("written", exp_r.written, rsp_tdata[0]);
            if (rsp_tdata[VIS_W:1] !== exp_r.visibility)
               report_mismatch("visibility", exp_r.visibility, rsp_tdata[VIS_W:1]);
         end
         if (rsp_tdata[RSP_DATA_W-1:VIS_W+1] !== '0)
            report_mismatch("pad bits", 0, rsp_tdata[RSP_DATA_W-1:VIS_W+1]);
         n_results++;
      end
   end

   task automatic send_item(depth_req_type rq);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_DATA_W'({$urandom, $urandom, $urandom, $urandom});
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.op;
      req_tdata  <= {rq.bias, rq.qd, rq.qy, rq.qx, rq.wd, rq.wy, rq.wx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted_results.insert(predicted_results.size(), apply_map_op(rq));
      n_items++;
      if (predicted_results[$].written) n_stored++;
      if (rq.op == OP_QUERY) n_queries++;
      if (rq.op == OP_CLEAR) n_clears++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (predicted_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_MAP_WIDTH:  cfg_width   = val[DIM_W-1:0];
         CSR_MAP_HEIGHT: cfg_height  = val[DIM_W-1:0];
         CSR_PCF_RADIUS: cfg_radius  = val[RAD_W-1:0];
         CSR_MIN_VIS:    cfg_min_vis = val[VIS_W-1:0];
         default: ;
      endcase
   endtask

   // only called with nothing in flight
   task automatic apply_config(int w, int h, int r, int mv);
      write_csr(CSR_MAP_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_MAP_HEIGHT, CSR_DATA_W'(h));
      write_csr(CSR_PCF_RADIUS, CSR_DATA_W'(r));
      write_csr(CSR_MIN_VIS, CSR_DATA_W'(mv));
      csr_valid <= 1'b0;
      n_configs++;
   endtask

   function automatic depth_req_type random_fields();
      depth_req_type rq;
      rq = REQ_BITS'({$urandom, $urandom, $urandom, $urandom});
      return rq;
   endfunction

   function automatic depth_req_type mk_write(int x, int y, int d);
      depth_req_type rq;
      rq = random_fields();
      rq.op = OP_WRITE;
      rq.wx = 8'(x);
      rq.wy = 8'(y);
      rq.wd = 24'(d);
      return rq;
   endfunction

   function automatic depth_req_type mk_query(int qx, int qy, int qd, int b);
      depth_req_type rq;
      rq = random_fields();
      rq.op   = OP_QUERY;
      rq.qx   = 12'(qx);
      rq.qy   = 12'(qy);
      rq.qd   = 24'(qd);
      rq.bias = 24'(b);
      return rq;
   endfunction

   function automatic depth_req_type mk_op(op_type op);
      depth_req_type rq;
      rq = random_fields();
      rq.op = op;
      return rq;
   endfunction

   function automatic logic [23:0] pick_depth();
      case ($urandom_range(9))
         0:       return 24'($urandom);
         1, 2:    return 24'(int'($urandom_range(2 * Q1_22_ONE)) - Q1_22_ONE);
         3:       return ($urandom_range(1) != 0) ? 24'(Q1_22_ONE) : 24'(-Q1_22_ONE);
         default: return 24'($urandom_range(2047));
      endcase
   endfunction

   function automatic int pick_dim();
      case ($urandom_range(7))
         0:       return 1;
         1:       return 256;
         2:       return 0;
         3:       return 256 + $urandom_range(255);
         default: return $urandom_range(2, 12);
      endcase
   endfunction

   function automatic int pick_floor();
      case ($urandom_range(4))
         0:       return 0;
         1:       return 65536;
         2:       return $urandom_range(65537, 131071);
         default: return $urandom_range(65536);
      endcase
   endfunction

   // mostly well-formed writes and queries landing on the map in use
   function automatic depth_req_type random_map_item();
      depth_req_type rq;
      int w, h, pick;
      w = eff_dim(cfg_width, MAX_WIDTH_DEF);
      h = eff_dim(cfg_height, MAX_HEIGHT_DEF);
      pick = $urandom_range(99);
      if (pick < 46) begin
         rq = ($urandom_range(99) < 85) ?
              mk_write($urandom_range(w - 1), $urandom_range(h - 1), 0) :
              mk_write($urandom_range(255), $urandom_range(255), 0);
         rq.wd = pick_depth();
      end else if (pick < 96) begin
         rq = ($urandom_range(99) < 85) ?
              mk_query($urandom_range(w * 16 + 16), $urandom_range(h * 16 + 16), 0, 0) :
              mk_query($urandom_range(4095), $urandom_range(4095), 0, 0);
         if (rq.qx > 12'hFFF - 1) rq.qx = 12'hFFF;
         rq.qd   = pick_depth();
         rq.bias = ($urandom_range(3) != 0) ? 24'(int'($urandom_range(64)) - 32) : pick_depth();
      end else begin
         rq = mk_op(OP_NONE);
      end
      return rq;
   endfunction

   task automatic test_write_rules();
      send_item(mk_write(0, 0, -Q1_22_ONE));
      send_item(mk_write(0, 0, -Q1_22_ONE));
      send_item(mk_write(0, 0, Q1_22_ONE));
      send_item(mk_write(255, 255, Q1_22_ONE));
      send_item(mk_write(1, 0, 0));
      send_item(mk_write(0, 1, 24'h7FFFFF));
      send_item(mk_write(1, 1, 24'h800000));
   endtask

   task automatic test_query_rounding();
      send_item(mk_query(0, 0, Q1_22_ONE, 0));
      send_item(mk_query(8, 8, 0, 0));
      send_item(mk_query(7, 7, -Q1_22_ONE, -Q1_22_ONE));
      send_item(mk_query(4095, 4095, 24'h7FFFFF, 24'h800000));
      send_item(mk_query(4087, 4087, Q1_22_ONE, 0));
      send_item(mk_query(24, 24, 24'h7FFFFF, 24'h7FFFFF));
      send_item(mk_query(0, 0, Q1_22_ONE, -Q1_22_ONE));
   endtask

   task automatic test_unused_op_and_clear();
      send_item(mk_op(OP_NONE));
      send_item(mk_op(OP_CLEAR));
      send_item(mk_query(0, 0, 24'h7FFFFF, 24'h800000));
   endtask

   task automatic test_config_extremes();
      drain();
      apply_config(0, 0, 3, 131071);
      send_item(mk_write(0, 0, 100));
      send_item(mk_write(1, 0, 50));
      send_item(mk_write(0, 1, 50));
      send_item(mk_query(0, 0, 200, 0));
      drain();
      apply_config(511, 300, 0, 0);
      send_item(mk_query(0, 0, 200, 0));
      send_item(mk_write(255, 255, -5));
      send_item(mk_query(4080, 4080, 0, 0));
      drain();
      apply_config(3, 2, 2, 32768);
      send_item(mk_query(16, 16, 150, 0));
      send_item(mk_write(2, 1, 7));
      send_item(mk_query(40, 8, 8, 0));
   endtask

   task automatic test_random_phase(int idle_pct, int stall_pct, int count);
      int clear_at;
      drain();
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      apply_config(pick_dim(), pick_dim(), $urandom_range(3), pick_floor());
      clear_at = $urandom_range(40, count - 1);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            drain();
            apply_config(pick_dim(), pick_dim(), $urandom_range(3), pick_floor());
         end
         if (i == clear_at) send_item(mk_op(OP_CLEAR));
         else send_item(random_map_item());
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_WRITE;
      rsp_tready <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_MAP_WIDTH;
      csr_data   <= '0;
      cfg_width   = DIM_W'(256);
      cfg_height  = DIM_W'(256);
      cfg_radius  = RAD_W'(1);
      cfg_min_vis = '0;
      clear_map();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_write_rules();
      test_query_rounding();
      test_unused_op_and_clear();
      test_config_extremes();
      test_random_phase(0, 0, PHASE_ITEMS);
      test_random_phase(70, 0, PHASE_ITEMS);
      test_random_phase(0, 70, PHASE_ITEMS);
      test_random_phase(33, 33, PHASE_ITEMS);

      drain();
      repeat (120) @(posedge clock);
      $display("Ran %0d items: %0d depths stored, %0d shadow queries, %0d clears",
               n_items, n_stored, n_queries, n_clears);
      $display("Used %0d register settings, %0d results checked, %0d mismatches",
               n_configs, n_results, mismatches);
      if (mismatches == 0 && predicted_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
